// ===== rtl/core/polynomial_multiply_unit_assert.svh =====
// Assertion macros used by the checker file of the polynomial multiplier.
`ifndef POLYNOMIAL_MULTIPLY_UNIT_ASSERT_SVH
`define POLYNOMIAL_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pmu_pkg.sv =====
// Package of the polynomial multiplier: defaults, widths, request codes, state and control types.
package pmu_pkg;

  localparam int MAX_TERMS_DEF  = 32;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int PROD_W         = 37;  // width of a product coefficient
  localparam int CNT_W          = 6;   // counts, indexes and degree

  // request codes on req_type
  localparam logic REQ_LEFT  = 1'b0;
  localparam logic REQ_RIGHT = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } pmu_state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             adv;       // chain steps one degree
    logic             wr_left;   // write left coefficient at wr_idx
    logic             wr_right;  // write right coefficient at wr_idx
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] lc;        // left terms held; cells at or above are idle
  } pmu_ctrl_t;

endpackage

// ===== rtl/core/pmu_if.sv =====
// Valid/ready channel interfaces for coefficient input and product output.
interface pmu_in_if #(
  parameter int COEF_WIDTH = pmu_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COEF_WIDTH-1:0] coeff;
  logic                         coeff_last;

  modport source (output valid, req_type, coeff, coeff_last, input ready);
  modport sink   (input valid, req_type, coeff, coeff_last, output ready);
endinterface

interface pmu_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pmu_pkg::PROD_W-1:0] product_coeff;
  logic [pmu_pkg::CNT_W-1:0]        degree;
  logic                             result_last;
  logic                             dropped_terms;

  modport source (output valid, product_coeff, degree, result_last, dropped_terms,
                  input ready);
  modport sink   (input valid, product_coeff, degree, result_last, dropped_terms,
                  output ready);
endinterface

// ===== rtl/core/pmu_cell.sv =====
// One cell of the convolution chain: a left term, a right term slot and a partial sum.
module pmu_cell
  import pmu_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pmu_ctrl_t                    ctrl,
  input  logic signed [COEF_WIDTH-1:0] din,
  input  logic signed [COEF_WIDTH-1:0] x,
  input  logic signed [COEF_WIDTH-1:0] b_in,
  output logic signed [COEF_WIDTH-1:0] b_out,
  input  logic signed [PROD_W-1:0]     s_in,
  output logic signed [PROD_W-1:0]     s_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [COEF_WIDTH-1:0]   a_r;
  logic signed [COEF_WIDTH-1:0]   b_r;
  logic signed [PROD_W-1:0]       s_r;
  logic signed [2*COEF_WIDTH-1:0] mul;
  logic signed [PROD_W-1:0]       term;
  logic                           active;
  logic                           sel;

  assign sel    = (ctrl.wr_idx == MY_IDX);
  assign active = (MY_IDX < ctrl.lc);

  // multiply-accumulate, the product sign-extended to the product width
  assign mul  = a_r * x;
  assign term = active ? PROD_W'(mul) : '0;

  // left term is stationary
  always_ff @(posedge clk) begin
    if (ctrl.wr_left && sel) begin
      a_r <= din;
    end
  end

  // right terms load by index and shift toward cell zero while stepping
  always_ff @(posedge clk) begin
    if (ctrl.wr_right && sel) begin
      b_r <= din;
    end else if (ctrl.adv) begin
      b_r <= b_in;
    end
  end

  // partial sums flow toward cell zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (ctrl.adv) begin
      s_r <= term + s_in;
    end
  end

  assign b_out = b_r;
  assign s_out = s_r;

endmodule

// ===== rtl/core/pmu_chain.sv =====
// Row of convolution cells; cell zero delivers the finished coefficient.
module pmu_chain
  import pmu_pkg::*;
#(
  parameter int MAX_TERMS  = MAX_TERMS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pmu_ctrl_t                    ctrl,
  input  logic signed [COEF_WIDTH-1:0] din,
  input  logic signed [COEF_WIDTH-1:0] x,
  output logic signed [COEF_WIDTH-1:0] b_head,
  output logic signed [PROD_W-1:0]     s_head
);

  logic signed [COEF_WIDTH-1:0] b_link [MAX_TERMS+1];
  logic signed [PROD_W-1:0]     s_link [MAX_TERMS+1];

  // far end feeds zeros
  assign b_link[MAX_TERMS] = '0;
  assign s_link[MAX_TERMS] = '0;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    pmu_cell #(
      .COEF_WIDTH (COEF_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .din   (din),
      .x     (x),
      .b_in  (b_link[i+1]),
      .b_out (b_link[i]),
      .s_in  (s_link[i+1]),
      .s_out (s_link[i])
    );
  end

  assign b_head = b_link[0];
  assign s_head = s_link[0];

endmodule

// ===== rtl/core/polynomial_multiply_unit.sv =====
// Top level of the polynomial multiplier: sequencer, output stage and cell chain.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    req_type, coeff, coeff_last
//   out_ch   out  valid/ready    product_coeff, degree, result_last, dropped_terms
//
// A coefficient transfers whenever in_ch.valid and in_ch.ready are both high.
// The right coefficient marked last starts the product: in_ch.ready drops and the
// cell chain steps once per cycle unless out_ch stalls, giving lc+rc-1 results (lc taken as 1 when empty).
// A stall on out_ch freezes the whole chain; cell zero's sum is the output register.
// Reset clears the counts, the drop flag and every partial sum; stores are not cleared.
module polynomial_multiply_unit
  import pmu_pkg::*;
#(
  parameter int MAX_TERMS  = MAX_TERMS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pmu_in_if.sink    in_ch,
  pmu_out_if.source out_ch
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

  pmu_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] lc_r, rc_r, k_r, last_idx_r;
  logic             ovf_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] deg_r;
  logic             last_r, drop_r;

  logic             in_xfer, is_right, lc_full, rc_full;
  logic             store_left, store_right, start, adv, step_last;
  logic [CNT_W-1:0] rc_new, lc_eff;
  logic signed [COEF_WIDTH-1:0] x, b_head;
  logic signed [PROD_W-1:0]     s_head;
  pmu_ctrl_t        ctrl;

  // input decode
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_right    = (in_ch.req_type == REQ_RIGHT);
  assign lc_full     = (lc_r == FULL);
  assign rc_full     = (rc_r == FULL);
  assign store_left  = in_xfer && !is_right && !lc_full;
  assign store_right = in_xfer && is_right && !rc_full;
  assign start       = in_xfer && is_right && in_ch.coeff_last;
  assign rc_new      = store_right ? rc_r + ONE : rc_r;
  assign lc_eff      = (lc_r == '0) ? ONE : lc_r;

  // chain stepping
  assign adv       = (state_r == ST_RUN) && (!out_valid_r || out_ch.ready);
  assign step_last = (k_r == last_idx_r);
  assign x         = (k_r < rc_r) ? b_head : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (adv && step_last) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_r)
      ST_LOAD: in_ch.ready = 1'b1;
      ST_RUN:  in_ch.ready = 1'b0;
      default: in_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operand counts and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      rc_r  <= '0;
      ovf_r <= 1'b0;
    end else if (adv && step_last) begin
      lc_r  <= '0;
      rc_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (store_left) lc_r <= lc_r + ONE;
      rc_r <= rc_new;
      if (in_xfer && (is_right ? rc_full : lc_full)) ovf_r <= 1'b1;
    end
  end

  // degree counter; last degree is lc+rc-2 (lc taken as 1 when empty), wraps cleanly in CNT_W bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      last_idx_r <= '0;
    end else if (start) begin
      k_r        <= '0;
      last_idx_r <= lc_eff + rc_new - TWO;
    end else if (adv) begin
      k_r <= k_r + ONE;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r  <= k_r;
      last_r <= step_last;
      drop_r <= ovf_r;
    end
  end

  assign ctrl.adv      = adv;
  assign ctrl.wr_left  = store_left;
  assign ctrl.wr_right = store_right;
  assign ctrl.wr_idx   = is_right ? rc_r : lc_r;
  assign ctrl.lc       = lc_r;

  pmu_chain #(
    .MAX_TERMS  (MAX_TERMS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .din    (in_ch.coeff),
    .x      (x),
    .b_head (b_head),
    .s_head (s_head)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_coeff = s_head;
  assign out_ch.degree        = deg_r;
  assign out_ch.result_last   = last_r;
  assign out_ch.dropped_terms = drop_r;

endmodule

// ===== rtl/core/pmu_checker.sv =====
// Port-level checker of the polynomial multiplier and its bind to the top level.
`include "polynomial_multiply_unit_assert.svh"

module pmu_checker
  import pmu_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_req_type,
  input logic              in_coeff_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_result_last,
  input logic [PROD_W-1:0] out_product_coeff
);

  // a started product closes the input side
  `PMU_ASSERT_NEXT(a_start_blocks, in_valid && in_ready && (in_req_type == REQ_RIGHT) && in_coeff_last, !in_ready, "input still ready after product start")

  // mid-product results never coexist with an open input
  `PMU_ASSERT_NOW(a_busy_mid, out_valid && !out_result_last, !in_ready, "input ready during product")

  // stalled result holds
  `PMU_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PMU_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(out_product_coeff), "result changed while stalled")

endmodule

bind polynomial_multiply_unit pmu_checker u_pmu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_req_type       (in_ch.req_type),
  .in_coeff_last     (in_ch.coeff_last),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_result_last   (out_ch.result_last),
  .out_product_coeff (out_ch.product_coeff)
);
